FILE: rtl/core/obb_sat_pkg.sv
`timescale 1ns / 1ps

package obb_sat_pkg;

  // field and coordinate widths
  localparam int FIELD_W = 32;
  localparam int COORD_W = 32;

  // derived arithmetic widths, all exact
  localparam int DIFF_W = COORD_W + 1;          // centre difference
  localparam int EP_W   = 2 * COORD_W;          // edge by edge product
  localparam int CP_W   = 2 * COORD_W + 1;      // edge by difference product
  localparam int ED_W   = 2 * COORD_W + 1;      // edge dot product, signed
  localparam int CD_W   = 2 * COORD_W + 2;      // centre dot product, signed
  localparam int EA_W   = 2 * COORD_W;          // magnitude of edge dot
  localparam int CA_W   = 2 * COORD_W + 1;      // magnitude of centre dot
  localparam int PS_W   = 2 * COORD_W + 1;      // sum of a pair of edge magnitudes
  localparam int SUM_W  = 2 * COORD_W + 2;      // sum of four, and doubled centre

  localparam int NUM_AXES   = 4;
  localparam int NUM_PAIRS  = 10;
  localparam int NUM_STAGES = 7;
  localparam int AXIS_W     = 3;

  localparam logic [AXIS_W-1:0] AXIS_NONE = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [EP_W-1:0]    eprod_t;
  typedef logic signed [CP_W-1:0]    cprod_t;
  typedef logic signed [ED_W-1:0]    edot_t;
  typedef logic signed [CD_W-1:0]    cdot_t;
  typedef logic [EA_W-1:0]           emag_t;
  typedef logic [CA_W-1:0]           cmag_t;
  typedef logic [PS_W-1:0]           psum_t;
  typedef logic [SUM_W-1:0]          wsum_t;
  typedef logic [AXIS_W-1:0]         axis_t;

  // load enables of the stages below the input stage
  typedef struct packed {
    logic mul_en;
    logic dot_en;
    logic abs_en;
    logic pair_en;
    logic sum_en;
    logic out_en;
  } obb_sat_en_t;

  // the ten distinct edge pairs; |a.b| is symmetric so each is computed once
  localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                                2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                                2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // pair slot for axis i against edge j
  localparam logic [3:0] PAIR_IDX [NUM_AXES][NUM_AXES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3},
    '{4'd1, 4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd5, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd8, 4'd9}
  };

endpackage

FILE: rtl/core/obb_sat_in_if.sv
`timescale 1ns / 1ps

interface obb_sat_in_if import obb_sat_pkg::*; ();

  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] left_edge_a_x;
  logic signed [FIELD_W-1:0] left_edge_a_y;
  logic signed [FIELD_W-1:0] left_edge_b_x;
  logic signed [FIELD_W-1:0] left_edge_b_y;
  logic signed [FIELD_W-1:0] right_edge_a_x;
  logic signed [FIELD_W-1:0] right_edge_a_y;
  logic signed [FIELD_W-1:0] right_edge_b_x;
  logic signed [FIELD_W-1:0] right_edge_b_y;
  logic signed [FIELD_W-1:0] left_center_x;
  logic signed [FIELD_W-1:0] left_center_y;
  logic signed [FIELD_W-1:0] right_center_x;
  logic signed [FIELD_W-1:0] right_center_y;

  modport source (
    output valid, left_edge_a_x, left_edge_a_y, left_edge_b_x, left_edge_b_y,
           right_edge_a_x, right_edge_a_y, right_edge_b_x, right_edge_b_y,
           left_center_x, left_center_y, right_center_x, right_center_y,
    input  ready
  );

  modport sink (
    input  valid, left_edge_a_x, left_edge_a_y, left_edge_b_x, left_edge_b_y,
           right_edge_a_x, right_edge_a_y, right_edge_b_x, right_edge_b_y,
           left_center_x, left_center_y, right_center_x, right_center_y,
    output ready
  );

endinterface

FILE: rtl/core/obb_sat_out_if.sv
`timescale 1ns / 1ps

interface obb_sat_out_if import obb_sat_pkg::*; ();

  logic  valid;
  logic  ready;
  logic  overlapping;
  axis_t separating_axis;

  modport source (
    output valid, overlapping, separating_axis,
    input  ready
  );

  modport sink (
    input  valid, overlapping, separating_axis,
    output ready
  );

endinterface

FILE: rtl/core/obb_sat_mul.sv
`timescale 1ns / 1ps

module obb_sat_mul import obb_sat_pkg::*; (
  input  logic        clk,
  input  obb_sat_en_t en,
  input  coord_t      edge_x [NUM_AXES],
  input  coord_t      edge_y [NUM_AXES],
  input  diff_t       dx,
  input  diff_t       dy,
  output eprod_t      epx_r [NUM_PAIRS],
  output eprod_t      epy_r [NUM_PAIRS],
  output cprod_t      cpx_r [NUM_AXES],
  output cprod_t      cpy_r [NUM_AXES]
);

  eprod_t epx_nxt [NUM_PAIRS];
  eprod_t epy_nxt [NUM_PAIRS];
  cprod_t cpx_nxt [NUM_AXES];
  cprod_t cpy_nxt [NUM_AXES];

  // edge by edge products for the distinct pairs
  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      epx_nxt[k] = EP_W'(edge_x[PAIR_A[k]]) * EP_W'(edge_x[PAIR_B[k]]);
      epy_nxt[k] = EP_W'(edge_y[PAIR_A[k]]) * EP_W'(edge_y[PAIR_B[k]]);
    end
  end

  // axis by centre difference products
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cpx_nxt[i] = CP_W'(edge_x[i]) * CP_W'(dx);
      cpy_nxt[i] = CP_W'(edge_y[i]) * CP_W'(dy);
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      epx_r <= epx_nxt;
      epy_r <= epy_nxt;
      cpx_r <= cpx_nxt;
      cpy_r <= cpy_nxt;
    end
  end

endmodule

FILE: rtl/core/obb_sat_accum.sv
`timescale 1ns / 1ps

module obb_sat_accum import obb_sat_pkg::*; (
  input  logic        clk,
  input  obb_sat_en_t en,
  input  eprod_t      epx [NUM_PAIRS],
  input  eprod_t      epy [NUM_PAIRS],
  input  cprod_t      cpx [NUM_AXES],
  input  cprod_t      cpy [NUM_AXES],
  output wsum_t       sum_r [NUM_AXES],
  output wsum_t       cen_r [NUM_AXES]
);

  edot_t edot_r   [NUM_PAIRS];
  edot_t edot_nxt [NUM_PAIRS];
  cdot_t cdot_r   [NUM_AXES];
  cdot_t cdot_nxt [NUM_AXES];
  emag_t emag_r   [NUM_PAIRS];
  emag_t emag_nxt [NUM_PAIRS];
  wsum_t cen2_r   [NUM_AXES];
  wsum_t cen2_nxt [NUM_AXES];
  psum_t plo_r    [NUM_AXES];
  psum_t plo_nxt  [NUM_AXES];
  psum_t phi_r    [NUM_AXES];
  psum_t phi_nxt  [NUM_AXES];
  wsum_t cen3_r   [NUM_AXES];
  wsum_t sum_nxt  [NUM_AXES];
  cmag_t cmag;

  // dot products from the product pairs
  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      edot_nxt[k] = ED_W'(epx[k]) + ED_W'(epy[k]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      cdot_nxt[i] = CD_W'(cpx[i]) + CD_W'(cpy[i]);
    end
  end

  // magnitudes; the centre side is doubled here
  always_comb begin
    cmag = '0;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      emag_nxt[k] = edot_r[k][ED_W-1] ? EA_W'(-edot_r[k]) : EA_W'(edot_r[k]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      cmag        = cdot_r[i][CD_W-1] ? CA_W'(-cdot_r[i]) : CA_W'(cdot_r[i]);
      cen2_nxt[i] = {cmag, 1'b0};
    end
  end

  // two partial sums per axis
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      plo_nxt[i] = PS_W'(emag_r[PAIR_IDX[i][0]]) + PS_W'(emag_r[PAIR_IDX[i][1]]);
      phi_nxt[i] = PS_W'(emag_r[PAIR_IDX[i][2]]) + PS_W'(emag_r[PAIR_IDX[i][3]]);
    end
  end

  // full projected extent per axis
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_nxt[i] = SUM_W'(plo_r[i]) + SUM_W'(phi_r[i]);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en.dot_en) begin
      edot_r <= edot_nxt;
      cdot_r <= cdot_nxt;
    end
    if (en.abs_en) begin
      emag_r <= emag_nxt;
      cen2_r <= cen2_nxt;
    end
    if (en.pair_en) begin
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      cen3_r <= cen2_r;
    end
    if (en.sum_en) begin
      sum_r <= sum_nxt;
      cen_r <= cen3_r;
    end
  end

endmodule

FILE: rtl/core/obb_sat_cmp.sv
`timescale 1ns / 1ps

module obb_sat_cmp import obb_sat_pkg::*; (
  input  logic        clk,
  input  obb_sat_en_t en,
  input  wsum_t       sum [NUM_AXES],
  input  wsum_t       cen [NUM_AXES],
  output logic        overlapping_r,
  output axis_t       axis_r
);

  logic [NUM_AXES-1:0] sep;
  axis_t               axis_nxt;
  logic                overlapping_nxt;

  // an axis separates when the extent falls strictly short of the gap
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sep[i] = sum[i] < cen[i];
    end
  end

  // first separating axis wins
  always_comb begin
    priority if (sep[0]) begin
      axis_nxt = 3'd0;
    end else if (sep[1]) begin
      axis_nxt = 3'd1;
    end else if (sep[2]) begin
      axis_nxt = 3'd2;
    end else if (sep[3]) begin
      axis_nxt = 3'd3;
    end else begin
      axis_nxt = AXIS_NONE;
    end
    overlapping_nxt = ~|sep;
  end

  // output register
  always_ff @(posedge clk) begin
    if (en.out_en) begin
      axis_r        <= axis_nxt;
      overlapping_r <= overlapping_nxt;
    end
  end

endmodule

FILE: rtl/core/obb_sat_2d_separating_axis_test.sv
`timescale 1ns / 1ps

// Separating axis overlap test for two oriented rectangles in 2D. One box pair
// is accepted per clock cycle while the output side takes results. The
// seven-stage pipeline runs input register, 28 parallel multipliers, dot sums,
// magnitudes, two summing stages, compare and encode; every stage holds one
// item, so the sustained rate is one item per cycle whenever the output side
// takes results. A stall at the output holds items in place stage by stage
// while empty stages further up keep filling. All arithmetic is exact, so the
// fixed-point scale never changes the answer; a tie or a zero edge counts as
// overlap.

module obb_2d_separating_axis_test import obb_sat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  obb_sat_in_if.sink        in_ch,
  obb_sat_out_if.source     out_ch
);

  logic [NUM_STAGES:1]   stage_v_r;
  logic [NUM_STAGES:1]   stage_v_nxt;
  logic [NUM_STAGES+1:1] stage_rdy;
  obb_sat_en_t           en;

  coord_t edge_x_r   [NUM_AXES];
  coord_t edge_y_r   [NUM_AXES];
  coord_t edge_x_nxt [NUM_AXES];
  coord_t edge_y_nxt [NUM_AXES];
  diff_t  dx_r;
  diff_t  dy_r;
  diff_t  dx_nxt;
  diff_t  dy_nxt;

  eprod_t epx [NUM_PAIRS];
  eprod_t epy [NUM_PAIRS];
  cprod_t cpx [NUM_AXES];
  cprod_t cpy [NUM_AXES];
  wsum_t  sum [NUM_AXES];
  wsum_t  cen [NUM_AXES];

  // per-stage ready: a stage loads when empty or when its successor loads
  always_comb begin
    stage_rdy[NUM_STAGES+1] = out_ch.ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      stage_rdy[k] = !stage_v_r[k] || stage_rdy[k+1];
    end
    stage_v_nxt[1] = stage_rdy[1] ? in_ch.valid : stage_v_r[1];
    for (int k = 2; k <= NUM_STAGES; k++) begin
      stage_v_nxt[k] = stage_rdy[k] ? stage_v_r[k-1] : stage_v_r[k];
    end
  end

  assign en.mul_en  = stage_rdy[2];
  assign en.dot_en  = stage_rdy[3];
  assign en.abs_en  = stage_rdy[4];
  assign en.pair_en = stage_rdy[5];
  assign en.sum_en  = stage_rdy[6];
  assign en.out_en  = stage_rdy[7];

  assign in_ch.ready = stage_rdy[1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  // input stage: edges as axes, centre difference
  always_comb begin
    edge_x_nxt[0] = coord_t'(in_ch.left_edge_a_x[COORD_W-1:0]);
    edge_y_nxt[0] = coord_t'(in_ch.left_edge_a_y[COORD_W-1:0]);
    edge_x_nxt[1] = coord_t'(in_ch.left_edge_b_x[COORD_W-1:0]);
    edge_y_nxt[1] = coord_t'(in_ch.left_edge_b_y[COORD_W-1:0]);
    edge_x_nxt[2] = coord_t'(in_ch.right_edge_a_x[COORD_W-1:0]);
    edge_y_nxt[2] = coord_t'(in_ch.right_edge_a_y[COORD_W-1:0]);
    edge_x_nxt[3] = coord_t'(in_ch.right_edge_b_x[COORD_W-1:0]);
    edge_y_nxt[3] = coord_t'(in_ch.right_edge_b_y[COORD_W-1:0]);
    dx_nxt = DIFF_W'(coord_t'(in_ch.left_center_x[COORD_W-1:0]))
           - DIFF_W'(coord_t'(in_ch.right_center_x[COORD_W-1:0]));
    dy_nxt = DIFF_W'(coord_t'(in_ch.left_center_y[COORD_W-1:0]))
           - DIFF_W'(coord_t'(in_ch.right_center_y[COORD_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[1]) begin
      edge_x_r <= edge_x_nxt;
      edge_y_r <= edge_y_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
    end
  end

  obb_sat_mul u_mul (
    .clk    (clk),
    .en     (en),
    .edge_x (edge_x_r),
    .edge_y (edge_y_r),
    .dx     (dx_r),
    .dy     (dy_r),
    .epx_r  (epx),
    .epy_r  (epy),
    .cpx_r  (cpx),
    .cpy_r  (cpy)
  );

  obb_sat_accum u_accum (
    .clk   (clk),
    .en    (en),
    .epx   (epx),
    .epy   (epy),
    .cpx   (cpx),
    .cpy   (cpy),
    .sum_r (sum),
    .cen_r (cen)
  );

  obb_sat_cmp u_cmp (
    .clk           (clk),
    .en            (en),
    .sum           (sum),
    .cen           (cen),
    .overlapping_r (out_ch.overlapping),
    .axis_r        (out_ch.separating_axis)
  );

  assign out_ch.valid = stage_v_r[NUM_STAGES];

`ifndef NO_ASSERTIONS
  // flag and axis index agree on every result
  a_flag_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.overlapping == (out_ch.separating_axis == AXIS_NONE)))
    else $error("overlap flag disagrees with separating axis");

  // axis index stays within its range
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.separating_axis <= AXIS_NONE))
    else $error("separating axis out of range");

  // a stalled item in the stage before the output stage stays there
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r[NUM_STAGES-1] && !stage_rdy[NUM_STAGES]) |=> stage_v_r[NUM_STAGES-1])
    else $error("stalled item dropped");

  // an item moving out of the stage before the output stage arrives in the output stage
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r[NUM_STAGES-1] && stage_rdy[NUM_STAGES]) |=> stage_v_r[NUM_STAGES])
    else $error("item lost between stages");
`endif

endmodule
